@@ rtl/pa_pkg.sv @@
`default_nettype none
package pa_pkg;

  localparam int TAG_BITS   = 16;
  localparam int COORD_BITS = 32;

  localparam int PORT_TAG_W = 16;
  localparam int PORT_Y_W   = 32;

  localparam int TAG_W   = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
  localparam int COORD_W = COORD_BITS;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_POINTS     = 3'd0,
    MODE_LINES      = 3'd1,
    MODE_LINE_STRIP = 3'd2,
    MODE_LINE_LOOP  = 3'd3,
    MODE_SPRITES    = 3'd4,
    MODE_TRIANGLES  = 3'd5,
    MODE_TRI_STRIP  = 3'd6,
    MODE_TRI_FAN    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_SPRITE = 2'd2,
    KIND_TRI    = 2'd3
  } kind_t;

  // one queued request; close adds the loop closing segment (b vertex to anchor)
  typedef struct packed {
    kind_t                     kind;
    logic [TAG_W-1:0]          tag_a;
    logic [TAG_W-1:0]          tag_b;
    logic [TAG_W-1:0]          tag_c;
    logic signed [COORD_W-1:0] y_a;
    logic signed [COORD_W-1:0] y_b;
    logic                      close;
    logic [TAG_W-1:0]          anchor_tag;
    logic signed [COORD_W-1:0] anchor_y;
  } prim_req_t;

endpackage
`default_nettype wire

@@ rtl/pa_front.sv @@
`default_nettype none
module pa_front import pa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PORT_TAG_W-1:0] in_vertex_tag,
  input  wire logic [PORT_Y_W-1:0]   in_vertex_y,
  input  wire logic                  in_last_vertex,
  input  wire logic                  q_full,
  output logic                       q_push,
  output prim_req_t                  q_push_data
);

  mode_t                     mode_r, mode_nxt;
  logic [1:0]                seen_r, seen_nxt;
  logic                      odd_r, odd_nxt;
  logic [TAG_W-1:0]          anchor_tag_r, anchor_tag_nxt;
  logic signed [COORD_W-1:0] anchor_y_r, anchor_y_nxt;
  logic [TAG_W-1:0]          older_tag_r, older_tag_nxt;
  logic signed [COORD_W-1:0] older_y_r, older_y_nxt;
  logic [TAG_W-1:0]          newer_tag_r, newer_tag_nxt;
  logic signed [COORD_W-1:0] newer_y_r, newer_y_nxt;

  logic                      accept;
  logic                      emit;
  logic [1:0]                seen_sat;
  logic [TAG_W-1:0]          tag;
  logic signed [COORD_W-1:0] y;
  prim_req_t                 req;

  assign tag      = in_vertex_tag[TAG_W-1:0];
  assign y        = $signed(in_vertex_y[COORD_W-1:0]);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign seen_sat = (seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1;

  always_comb begin
    mode_nxt       = mode_r;
    seen_nxt       = seen_r;
    odd_nxt        = odd_r;
    anchor_tag_nxt = anchor_tag_r;
    anchor_y_nxt   = anchor_y_r;
    older_tag_nxt  = older_tag_r;
    older_y_nxt    = older_y_r;
    newer_tag_nxt  = newer_tag_r;
    newer_y_nxt    = newer_y_r;
    emit           = 1'b0;
    req            = '0;
    req.anchor_tag = anchor_tag_r;
    req.anchor_y   = anchor_y_r;
    if (accept) begin
      unique case (mode_r)
        MODE_POINTS: begin
          emit      = 1'b1;
          req.kind  = KIND_POINT;
          req.tag_a = tag;
        end
        MODE_LINES, MODE_SPRITES: begin
          if (seen_r == 2'd0) begin
            newer_tag_nxt = tag;
            newer_y_nxt   = y;
            seen_nxt      = 2'd1;
          end else begin
            emit      = 1'b1;
            req.tag_a = newer_tag_r;
            req.tag_b = tag;
            if (mode_r == MODE_LINES) begin
              req.kind = KIND_LINE;
              req.y_a  = newer_y_r;
              req.y_b  = y;
            end else begin
              req.kind = KIND_SPRITE;
            end
            seen_nxt = 2'd0;
          end
        end
        MODE_TRIANGLES: begin
          if (seen_r == 2'd0) begin
            older_tag_nxt = tag;
            older_y_nxt   = y;
            seen_nxt      = 2'd1;
          end else if (seen_r == 2'd1) begin
            newer_tag_nxt = tag;
            newer_y_nxt   = y;
            seen_nxt      = 2'd2;
          end else begin
            emit      = 1'b1;
            req.kind  = KIND_TRI;
            req.tag_a = older_tag_r;
            req.tag_b = newer_tag_r;
            req.tag_c = tag;
            seen_nxt  = 2'd0;
          end
        end
        MODE_LINE_STRIP, MODE_LINE_LOOP: begin
          if (seen_r == 2'd0) begin
            anchor_tag_nxt = tag;
            anchor_y_nxt   = y;
          end else begin
            emit      = 1'b1;
            req.kind  = KIND_LINE;
            req.tag_a = newer_tag_r;
            req.y_a   = newer_y_r;
            req.tag_b = tag;
            req.y_b   = y;
            req.close = (mode_r == MODE_LINE_LOOP) && in_last_vertex;
          end
          newer_tag_nxt = tag;
          newer_y_nxt   = y;
          seen_nxt      = seen_sat;
        end
        MODE_TRI_STRIP: begin
          if (seen_r[1]) begin
            emit     = 1'b1;
            req.kind = KIND_TRI;
            if (odd_r) begin
              req.tag_a = tag;
              req.tag_b = newer_tag_r;
              req.tag_c = older_tag_r;
            end else begin
              req.tag_a = older_tag_r;
              req.tag_b = newer_tag_r;
              req.tag_c = tag;
            end
            odd_nxt = !odd_r;
          end
          older_tag_nxt = newer_tag_r;
          older_y_nxt   = newer_y_r;
          newer_tag_nxt = tag;
          newer_y_nxt   = y;
          seen_nxt      = seen_sat;
        end
        MODE_TRI_FAN: begin
          if (seen_r == 2'd0) begin
            anchor_tag_nxt = tag;
            anchor_y_nxt   = y;
          end else if (seen_r[1]) begin
            emit      = 1'b1;
            req.kind  = KIND_TRI;
            req.tag_a = anchor_tag_r;
            req.tag_b = newer_tag_r;
            req.tag_c = tag;
          end
          newer_tag_nxt = tag;
          newer_y_nxt   = y;
          seen_nxt      = seen_sat;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
      if (in_last_vertex) begin
        seen_nxt = 2'd0;
        odd_nxt  = 1'b0;
      end
    end
    if (cfg_wr_en) begin
      mode_nxt = mode_t'(cfg_wr_data);
      seen_nxt = 2'd0;
      odd_nxt  = 1'b0;
    end
  end

  assign q_push      = accept && emit;
  assign q_push_data = req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_POINTS;
      seen_r <= 2'd0;
      odd_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      seen_r <= seen_nxt;
      odd_r  <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    anchor_tag_r <= anchor_tag_nxt;
    anchor_y_r   <= anchor_y_nxt;
    older_tag_r  <= older_tag_nxt;
    older_y_r    <= older_y_nxt;
    newer_tag_r  <= newer_tag_nxt;
    newer_y_r    <= newer_y_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/pa_queue.sv @@
`default_nettype none
module pa_queue import pa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  prim_req_t      push_data,
  output logic           full,
  input  wire logic      pop,
  output prim_req_t      head,
  output logic           nonempty
);

  prim_req_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("request queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("request queue count out of range");

endmodule
`default_nettype wire

@@ rtl/pa_back.sv @@
`default_nettype none
module pa_back import pa_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  prim_req_t                   head,
  input  wire logic                   nonempty,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_prim_kind,
  output logic [PORT_TAG_W-1:0]       out_corner_a,
  output logic [PORT_TAG_W-1:0]       out_corner_b,
  output logic [PORT_TAG_W-1:0]       out_corner_c,
  output logic                        out_run_end
);

  logic                 phase_r, phase_nxt;
  logic                 valid_r, valid_nxt;
  kind_t                kind_r, kind_nxt;
  logic [TAG_W-1:0]     a_r, a_nxt;
  logic [TAG_W-1:0]     b_r, b_nxt;
  logic [TAG_W-1:0]     c_r, c_nxt;
  logic                 end_r, end_nxt;
  logic                 load;
  logic                 swap_first;
  logic                 swap_close;

  assign load       = nonempty && (!valid_r || !out_stall);
  assign swap_first = (head.kind == KIND_LINE) && (head.y_a > head.y_b);
  assign swap_close = head.y_b > head.anchor_y;

  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r && out_stall;
    kind_nxt  = kind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    end_nxt   = end_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      if (phase_r) begin
        kind_nxt  = KIND_LINE;
        a_nxt     = swap_close ? head.anchor_tag : head.tag_b;
        b_nxt     = swap_close ? head.tag_b : head.anchor_tag;
        c_nxt     = '0;
        end_nxt   = 1'b1;
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end else begin
        kind_nxt  = head.kind;
        a_nxt     = swap_first ? head.tag_b : head.tag_a;
        b_nxt     = swap_first ? head.tag_a : head.tag_b;
        c_nxt     = head.tag_c;
        end_nxt   = !head.close;
        phase_nxt = head.close;
        pop       = !head.close;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid     = valid_r;
  assign out_prim_kind = kind_r;
  assign out_corner_a  = PORT_TAG_W'(a_r);
  assign out_corner_b  = PORT_TAG_W'(b_r);
  assign out_corner_c  = PORT_TAG_W'(c_r);
  assign out_run_end   = end_r;

  a_close_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (nonempty && head.close))
    else $error("closing segment pending without a loop close request");

  a_close_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !phase_r && head.close) |=> (!out_run_end && phase_r))
    else $error("first loop segment flagged as run end");

  a_point_corners: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_prim_kind == KIND_POINT)) |-> (out_corner_b == '0 && out_corner_c == '0))
    else $error("point with nonzero corners");

endmodule
`default_nettype wire

@@ rtl/primitive_assembler.sv @@
// Primitive assembler: groups a vertex stream into points, lines, sprites or
// triangles according to a 3-bit mode register (cfg_wr_en / cfg_wr_data).
// Writing the mode starts a fresh array; write it only while the block is idle.
// Input channel (in_*): one vertex per request, tag, y and a last-of-array flag.
// Output channel (out_*): one primitive per request; out_run_end marks the last
// primitive caused by a vertex. Line corners come out ordered by increasing y.
// A request moves on a channel at a clock edge with valid high and stall low.
// Throughput: one vertex per cycle while in_stall is low. A vertex that closes a line loop yields two
// primitives and holds the output side for a second load; the 4-deep request
// queue between the classifier and the output stage absorbs it.
// An accepted vertex's primitive is written into the request queue and then into
// the output register, which drives out_*.
// Vertices that complete no primitive produce nothing on the output channel;
// an unfinished pair or triple at the end of an array is dropped.
// out_stall high holds the output register; the queue then fills and in_stall
// rises once it holds four requests. in_stall depends only on queue occupancy.
// Reset (rst_n low, synchronous) sets points mode and empties the queue.
`default_nettype none
module primitive_assembler import pa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [2:0]            cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PORT_TAG_W-1:0] in_vertex_tag,
  input  wire logic [PORT_Y_W-1:0]   in_vertex_y,
  input  wire logic                  in_last_vertex,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_prim_kind,
  output logic [PORT_TAG_W-1:0]      out_corner_a,
  output logic [PORT_TAG_W-1:0]      out_corner_b,
  output logic [PORT_TAG_W-1:0]      out_corner_c,
  output logic                       out_run_end
);

  logic      q_full;
  logic      q_push;
  prim_req_t q_push_data;
  logic      q_pop;
  prim_req_t q_head;
  logic      q_nonempty;

  pa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vertex_tag  (in_vertex_tag),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_data    (q_push_data)
  );

  pa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  pa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .nonempty      (q_nonempty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prim_kind (out_prim_kind),
    .out_corner_a  (out_corner_a),
    .out_corner_b  (out_corner_b),
    .out_corner_c  (out_corner_c),
    .out_run_end   (out_run_end)
  );

endmodule
`default_nettype wire

@@ tb/primitive_assembler_tb.sv @@
module primitive_assembler_tb;
  import pa_pkg::*;

  typedef struct packed {
    kind_t                 kind;
    logic [PORT_TAG_W-1:0] a;
    logic [PORT_TAG_W-1:0] b;
    logic [PORT_TAG_W-1:0] c;
    logic                  run_end;
  } prim_t;

  typedef struct packed {
    mode_t                 mode;
    logic [PORT_TAG_W-1:0] tag;
    logic [PORT_Y_W-1:0]   y;
    logic                  last;
    logic                  typed;
    prim_t                 want;
  } step_t;

  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 25;
  localparam int DRAIN_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_wr_data = 3'd0;
  logic                  in_valid = 1'b0;
  logic [PORT_TAG_W-1:0] in_vertex_tag = '0;
  logic [PORT_Y_W-1:0]   in_vertex_y = '0;
  logic                  in_last_vertex = 1'b0;
  logic                  out_stall = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire [1:0]             out_prim_kind;
  wire [PORT_TAG_W-1:0]  out_corner_a;
  wire [PORT_TAG_W-1:0]  out_corner_b;
  wire [PORT_TAG_W-1:0]  out_corner_c;
  wire                   out_run_end;

  primitive_assembler uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vertex_tag (in_vertex_tag),
    .in_vertex_y   (in_vertex_y),
    .in_last_vertex(in_last_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prim_kind (out_prim_kind),
    .out_corner_a  (out_corner_a),
    .out_corner_b  (out_corner_b),
    .out_corner_c  (out_corner_c),
    .out_run_end   (out_run_end)
  );

  // assembler state mirror
  mode_t                      cur_mode = MODE_POINTS;
  logic [PORT_TAG_W-1:0]      anchor_tag = '0, older_tag = '0, newer_tag = '0;
  logic signed [PORT_Y_W-1:0] anchor_y = '0, older_y = '0, newer_y = '0;
  logic [1:0]                 seen_count = 2'd0;
  logic                       odd_winding = 1'b0;

  prim_t pending_prims[$];
  int    fault_count = 0;
  int    burst_left = 0;
  bit    gaps_on = 1'b1;
  int    stall_left = 0;
  int    stall_pct = 0;

  step_t plan [0:26] = '{
    '{MODE_POINTS,     16'h0000, 32'h0000_0000, 1'b0, 1'b1,
      '{KIND_POINT, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{MODE_POINTS,     16'hFFFF, 32'h7FFF_FFFF, 1'b1, 1'b1,
      '{KIND_POINT, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}},
    '{MODE_POINTS,     16'h8001, 32'h8000_0000, 1'b0, 1'b1,
      '{KIND_POINT, 16'h8001, 16'h0000, 16'h0000, 1'b1}},
    '{MODE_LINES,      16'h1111, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{MODE_LINES,      16'h2222, 32'h8000_0000, 1'b0, 1'b1,
      '{KIND_LINE, 16'h2222, 16'h1111, 16'h0000, 1'b1}},
    '{MODE_LINES,      16'h3333, 32'h0001_0000, 1'b0, 1'b0, '0},
    '{MODE_LINES,      16'h4444, 32'h0001_0000, 1'b0, 1'b1,
      '{KIND_LINE, 16'h3333, 16'h4444, 16'h0000, 1'b1}},
    '{MODE_SPRITES,    16'hAAAA, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{MODE_SPRITES,    16'h5555, 32'h0000_0000, 1'b1, 1'b1,
      '{KIND_SPRITE, 16'hAAAA, 16'h5555, 16'h0000, 1'b1}},
    '{MODE_TRIANGLES,  16'h0101, 32'h0000_0001, 1'b0, 1'b0, '0},
    '{MODE_TRIANGLES,  16'h0202, 32'h0000_0002, 1'b0, 1'b0, '0},
    '{MODE_TRIANGLES,  16'h0303, 32'h0000_0003, 1'b0, 1'b1,
      '{KIND_TRI, 16'h0101, 16'h0202, 16'h0303, 1'b1}},
    '{MODE_TRIANGLES,  16'h0404, 32'h0000_0004, 1'b1, 1'b0, '0},
    '{MODE_LINE_LOOP,  16'h0A0A, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{MODE_LINE_LOOP,  16'h0B0B, 32'h0000_0010, 1'b0, 1'b0, '0},
    '{MODE_LINE_LOOP,  16'h0C0C, 32'hFFFF_FFF0, 1'b1, 1'b0, '0},
    '{MODE_LINE_STRIP, 16'h0D0D, 32'h0000_0005, 1'b0, 1'b0, '0},
    '{MODE_LINE_STRIP, 16'h0E0E, 32'h0000_0003, 1'b0, 1'b0, '0},
    '{MODE_LINE_STRIP, 16'h0F0F, 32'h0000_0009, 1'b1, 1'b0, '0},
    '{MODE_TRI_STRIP,  16'h1001, 32'h0000_0007, 1'b0, 1'b0, '0},
    '{MODE_TRI_STRIP,  16'h1002, 32'hFFFF_0000, 1'b0, 1'b0, '0},
    '{MODE_TRI_STRIP,  16'h1003, 32'h0002_0000, 1'b0, 1'b0, '0},
    '{MODE_TRI_STRIP,  16'h1004, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{MODE_TRI_FAN,    16'h2001, 32'h0000_0001, 1'b0, 1'b0, '0},
    '{MODE_TRI_FAN,    16'h2002, 32'h0000_0002, 1'b0, 1'b0, '0},
    '{MODE_TRI_FAN,    16'h2003, 32'h0000_0003, 1'b0, 1'b0, '0},
    '{MODE_TRI_FAN,    16'h2004, 32'h0000_0004, 1'b1, 1'b0, '0}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("primitive_assembler_tb: errors");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 64);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  task automatic note_error(input string msg);
    if (fault_count < 10) $display("%s", msg);
    fault_count++;
  endtask

  function automatic void add_prim(input kind_t k, input logic [PORT_TAG_W-1:0] a,
                                   input logic [PORT_TAG_W-1:0] b,
                                   input logic [PORT_TAG_W-1:0] c);
    prim_t p;
    p = '{k, a, b, c, 1'b0};
    pending_prims.push_back(p);
  endfunction

  // segments run from smaller y to larger y; ties keep arrival order
  function automatic void add_line(input logic [PORT_TAG_W-1:0] ta,
                                   input logic signed [PORT_Y_W-1:0] ya,
                                   input logic [PORT_TAG_W-1:0] tb,
                                   input logic signed [PORT_Y_W-1:0] yb);
    if (ya > yb) add_prim(KIND_LINE, tb, ta, '0);
    else add_prim(KIND_LINE, ta, tb, '0);
  endfunction

  function automatic void assemble_vertex(input logic [PORT_TAG_W-1:0] t,
                                          input logic signed [PORT_Y_W-1:0] y,
                                          input logic last);
    int base;
    logic [1:0] next_seen;
    base = pending_prims.size();
    next_seen = (seen_count == 2'd3) ? 2'd3 : seen_count + 2'd1;
    case (cur_mode)
      MODE_POINTS: add_prim(KIND_POINT, t, '0, '0);
      MODE_LINES, MODE_SPRITES: begin
        if (seen_count == 2'd0) begin
          newer_tag = t;
          newer_y = y;
          seen_count = 2'd1;
        end else begin
          if (cur_mode == MODE_LINES) add_line(newer_tag, newer_y, t, y);
          else add_prim(KIND_SPRITE, newer_tag, t, '0);
          seen_count = 2'd0;
        end
      end
      MODE_TRIANGLES: begin
        if (seen_count == 2'd0) begin
          older_tag = t;
          older_y = y;
          seen_count = 2'd1;
        end else if (seen_count == 2'd1) begin
          newer_tag = t;
          newer_y = y;
          seen_count = 2'd2;
        end else begin
          add_prim(KIND_TRI, older_tag, newer_tag, t);
          seen_count = 2'd0;
        end
      end
      MODE_LINE_STRIP, MODE_LINE_LOOP: begin
        if (seen_count == 2'd0) begin
          anchor_tag = t;
          anchor_y = y;
        end else begin
          add_line(newer_tag, newer_y, t, y);
          if (cur_mode == MODE_LINE_LOOP && last) add_line(t, y, anchor_tag, anchor_y);
        end
        newer_tag = t;
        newer_y = y;
        seen_count = next_seen;
      end
      MODE_TRI_STRIP: begin
        if (seen_count >= 2'd2) begin
          if (odd_winding) add_prim(KIND_TRI, t, newer_tag, older_tag);
          else add_prim(KIND_TRI, older_tag, newer_tag, t);
          odd_winding = ~odd_winding;
        end
        older_tag = newer_tag;
        older_y = newer_y;
        newer_tag = t;
        newer_y = y;
        seen_count = next_seen;
      end
      default: begin
        if (seen_count == 2'd0) begin
          anchor_tag = t;
          anchor_y = y;
        end else if (seen_count >= 2'd2) begin
          add_prim(KIND_TRI, anchor_tag, newer_tag, t);
        end
        newer_tag = t;
        newer_y = y;
        seen_count = next_seen;
      end
    endcase
    if (last) begin
      seen_count = 2'd0;
      odd_winding = 1'b0;
    end
    if (pending_prims.size() > base) pending_prims[pending_prims.size() - 1].run_end = 1'b1;
  endfunction

  task automatic send_vertex(input logic [PORT_TAG_W-1:0] tag, input logic [PORT_Y_W-1:0] y,
                             input logic last, input logic typed, input prim_t want);
    int gap;
    int base;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_vertex_tag = tag;
    in_vertex_y = y;
    in_last_vertex = last;
    do @(posedge clk); while (in_stall);
    base = pending_prims.size();
    assemble_vertex(tag, y, last);
    if (typed) begin
      while (pending_prims.size() > base) void'(pending_prims.pop_back());
      pending_prims.push_back(want);
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_prims.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_prims.size() != 0) begin
      note_error($sformatf("%0t: %0d primitives never arrived", $time, pending_prims.size()));
      pending_prims.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    drain_results();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_mode = m;
    seen_count = 2'd0;
    odd_winding = 1'b0;
  endtask

  function automatic logic [PORT_Y_W-1:0] pick_y();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin : check_out
    prim_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_prims.size() == 0) begin
        note_error($sformatf("%0t: unrequested primitive kind=%0d a=%h b=%h c=%h end=%b",
                             $time, out_prim_kind, out_corner_a, out_corner_b,
                             out_corner_c, out_run_end));
      end else begin
        want = pending_prims.pop_front();
        if (out_prim_kind !== want.kind || out_corner_a !== want.a ||
            out_corner_b !== want.b || out_corner_c !== want.c ||
            out_run_end !== want.run_end)
          note_error($sformatf({"%0t: primitive mismatch want kind=%0d a=%h b=%h c=%h end=%b",
                                " got kind=%0d a=%h b=%h c=%h end=%b"},
                               $time, want.kind, want.a, want.b, want.c, want.run_end,
                               out_prim_kind, out_corner_a, out_corner_b, out_corner_c,
                               out_run_end));
      end
    end
  end

  initial begin
    int i, ph, sent, len, k;
    logic last;
    mode_t m;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < $size(plan); i++) begin
      if (plan[i].mode != cur_mode) set_mode(plan[i].mode);
      send_vertex(plan[i].tag, plan[i].y, plan[i].last, plan[i].typed, plan[i].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      m = (ph < 8) ? mode_t'(ph[2:0]) : mode_t'($urandom_range(0, 7));
      set_mode(m);
      gaps_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        for (k = 0; k < len && sent < PHASE_ITEMS; k++) begin
          last = (k == len - 1);
          if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
          send_vertex(16'($urandom_range(0, 65535)), pick_y(), last, 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    if (fault_count == 0) begin
      $display("primitive_assembler_tb: clean");
    end else begin
      $display("primitive_assembler_tb: errors");
    end
    $finish;
  end

endmodule
